[rtl/arc_route_orientation_concat_assert.svh]
// Assertion macros shared by the orientation concatenation RTL.
`ifndef ARC_ROUTE_ORIENTATION_CONCAT_ASSERT_SVH
`define ARC_ROUTE_ORIENTATION_CONCAT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define AROC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aroc assertion failed: same-cycle implication");
// Next-cycle implication, checked on every rising edge outside reset.
`define AROC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aroc assertion failed: next-cycle implication");
`else
`define AROC_ASSERT_IMPL(label, ante, cons)
`define AROC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/aroc_pkg.sv]
// Types, constants and helper functions of the orientation concatenation block.
package aroc_pkg;

   localparam int COST_W  = 32;
   localparam int LOAD_W  = 24;
   localparam int DEM_W   = 16;
   localparam int SCORE_W = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COST_W-1:0]  COST_INF  = {COST_W{1'b1}};
   localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // Operation codes.
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_PREPEND = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_VEHICLE_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_LIMIT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY_PENALTY = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION_PENALTY = 2'd3;

   // Register reset values.
   localparam logic [LOAD_W-1:0] CAPACITY_RESET   = 24'hFF_FFFF;
   localparam logic [COST_W-1:0] TIME_LIMIT_RESET = 32'hFFFF_FFFE;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [COST_W-1:0] cost_forward;
      logic [COST_W-1:0] cost_reverse;
      logic [DEM_W-1:0]  demand;
      logic [COST_W-1:0] link_ff;
      logic [COST_W-1:0] link_ft;
      logic [COST_W-1:0] link_tf;
      logic [COST_W-1:0] link_tt;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0]  best_from_from;
      logic [COST_W-1:0]  best_from_to;
      logic [COST_W-1:0]  best_to_from;
      logic [COST_W-1:0]  best_to_to;
      logic [COST_W-1:0]  min_cost;
      logic [LOAD_W-1:0]  total_load;
      logic [LOAD_W-1:0]  excess_load;
      logic [COST_W-1:0]  excess_time;
      logic [SCORE_W-1:0] penalized_cost;
   } rsp_type;

   // Sequence state after one transaction, handed from front to back.
   typedef struct packed {
      logic [COST_W-1:0] cost_ff;
      logic [COST_W-1:0] cost_ft;
      logic [COST_W-1:0] cost_tf;
      logic [COST_W-1:0] cost_tt;
      logic [LOAD_W-1:0] load;
   } state_type;

   typedef struct packed {
      logic [LOAD_W-1:0] vehicle_capacity;
      logic [COST_W-1:0] time_limit;
      logic [LOAD_W-1:0] capacity_penalty;
      logic [LOAD_W-1:0] duration_penalty;
   } cfg_type;

   // Saturating add; the all-ones code is infinity and absorbs everything.
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, COST_INF}) begin
         return COST_INF;
      end
      return sum[COST_W-1:0];
   endfunction

   function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                              input logic [COST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

[rtl/aroc_fifo.sv]
// Small first-in first-out queue in flip-flops, used between and after the stages.
module aroc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers wrap at the depth, which need not be a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/aroc_front.sv]
// Front part: decodes each transaction and applies the min-plus update to the sequence state.
module aroc_front import aroc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output state_type state_next
);

   state_type       state_ff;
   state_type       state_in;
   logic [LOAD_W:0] load_sum;

   // Saturating load accumulation for append and prepend.
   assign load_sum = {1'b0, state_ff.load} + (LOAD_W + 1)'(req_data.demand);

   // Next state of the four orientation costs and the load.
   always_comb begin
      state_in = state_ff;
      case (req_data.opcode)
         OP_START: begin
            state_in.cost_ff = COST_INF;
            state_in.cost_tt = COST_INF;
            state_in.cost_ft = req_data.cost_forward;
            state_in.cost_tf = req_data.cost_reverse;
            state_in.load    = LOAD_W'(req_data.demand);
         end
         OP_APPEND: begin
            state_in.cost_ft = sat_add(min2(sat_add(state_ff.cost_ff, req_data.link_ff),
                                            sat_add(state_ff.cost_ft, req_data.link_tf)),
                                       req_data.cost_forward);
            state_in.cost_tt = sat_add(min2(sat_add(state_ff.cost_tf, req_data.link_ff),
                                            sat_add(state_ff.cost_tt, req_data.link_tf)),
                                       req_data.cost_forward);
            state_in.cost_ff = sat_add(min2(sat_add(state_ff.cost_ff, req_data.link_ft),
                                            sat_add(state_ff.cost_ft, req_data.link_tt)),
                                       req_data.cost_reverse);
            state_in.cost_tf = sat_add(min2(sat_add(state_ff.cost_tf, req_data.link_ft),
                                            sat_add(state_ff.cost_tt, req_data.link_tt)),
                                       req_data.cost_reverse);
            state_in.load    = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
         end
         OP_PREPEND: begin
            state_in.cost_ff = sat_add(min2(sat_add(state_ff.cost_ff, req_data.link_tf),
                                            sat_add(state_ff.cost_tf, req_data.link_tt)),
                                       req_data.cost_forward);
            state_in.cost_ft = sat_add(min2(sat_add(state_ff.cost_ft, req_data.link_tf),
                                            sat_add(state_ff.cost_tt, req_data.link_tt)),
                                       req_data.cost_forward);
            state_in.cost_tf = sat_add(min2(sat_add(state_ff.cost_ff, req_data.link_ff),
                                            sat_add(state_ff.cost_tf, req_data.link_ft)),
                                       req_data.cost_reverse);
            state_in.cost_tt = sat_add(min2(sat_add(state_ff.cost_ft, req_data.link_ff),
                                            sat_add(state_ff.cost_tt, req_data.link_ft)),
                                       req_data.cost_reverse);
            state_in.load    = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
         end
         default: begin
            // The unused code leaves the state as it is.
            state_in = state_ff;
         end
      endcase
   end

   assign state_next = state_in;

   // Sequence state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cost_ff <= COST_INF;
         state_ff.cost_ft <= COST_INF;
         state_ff.cost_tf <= COST_INF;
         state_ff.cost_tt <= COST_INF;
         state_ff.load    <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/aroc_back.sv]
// Back part: scores each sequence state in a short pipeline and queues the results.
`include "arc_route_orientation_concat_assert.svh"

module aroc_back import aroc_pkg::*; #(
   parameter int OUT_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      src_empty,
   input  state_type src_data,
   output logic      src_pop,
   input  logic      pop,
   output logic      empty,
   output rsp_type   rsp_data
);

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int OCC_W = CNT_W + 1;
   localparam int SUM_W = SCORE_W + 10;

   typedef struct packed {
      state_type         state;
      logic [COST_W-1:0] min_cost;
      logic [LOAD_W-1:0] excess_load;
      logic [COST_W-1:0] excess_time;
      logic              ff_inf;
   } stage_type;

   stage_type         s1_ff;
   stage_type         s1_in;
   stage_type         s2_ff;
   logic              v1_ff;
   logic              v2_ff;
   logic [47:0]       prod_load_ff;
   logic [55:0]       prod_time_ff;
   logic [SUM_W-1:0]  score_sum;
   rsp_type           out_data;
   logic              out_full;
   logic [CNT_W-1:0]  out_count;
   logic [OCC_W-1:0]  occupancy;
   logic              issue;
   logic [COST_W-1:0] min_lo;
   logic [COST_W-1:0] min_hi;

   // Issue only when the result queue has room for everything in flight.
   assign occupancy = OCC_W'(out_count) + OCC_W'(v1_ff) + OCC_W'(v2_ff);
   assign issue     = !src_empty && (occupancy < OCC_W'(OUT_DEPTH));
   assign src_pop   = issue;

   // First stage: minimum and both excesses.
   always_comb begin
      min_lo            = min2(src_data.cost_ff, src_data.cost_ft);
      min_hi            = min2(src_data.cost_tf, src_data.cost_tt);
      s1_in.state       = src_data;
      s1_in.min_cost    = min2(min_lo, min_hi);
      s1_in.excess_load = (src_data.load > cfg.vehicle_capacity) ?
                          src_data.load - cfg.vehicle_capacity : '0;
      s1_in.ff_inf      = (src_data.cost_ff == COST_INF);
      if (s1_in.ff_inf) begin
         s1_in.excess_time = COST_INF;
      end else if (src_data.cost_ff > cfg.time_limit) begin
         s1_in.excess_time = src_data.cost_ff - cfg.time_limit;
      end else begin
         s1_in.excess_time = '0;
      end
   end

   // Pipeline payload: stage one, then the two penalty products.
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s1_ff;
      prod_load_ff <= 48'(s1_ff.excess_load) * 48'(cfg.capacity_penalty);
      prod_time_ff <= 56'(s1_ff.excess_time) * 56'(cfg.duration_penalty);
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   // Final sum in Q40.8 with saturation.
   assign score_sum = SUM_W'({s2_ff.state.cost_ff, 8'h00}) + SUM_W'(prod_load_ff)
                      + SUM_W'(prod_time_ff);

   always_comb begin
      out_data.best_from_from = s2_ff.state.cost_ff;
      out_data.best_from_to   = s2_ff.state.cost_ft;
      out_data.best_to_from   = s2_ff.state.cost_tf;
      out_data.best_to_to     = s2_ff.state.cost_tt;
      out_data.min_cost       = s2_ff.min_cost;
      out_data.total_load     = s2_ff.state.load;
      out_data.excess_load    = s2_ff.excess_load;
      out_data.excess_time    = s2_ff.excess_time;
      if (s2_ff.ff_inf || (score_sum > SUM_W'(SCORE_MAX))) begin
         out_data.penalized_cost = SCORE_MAX;
      end else begin
         out_data.penalized_cost = score_sum[SCORE_W-1:0];
      end
   end

   // Result queue towards the receiver.
   aroc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (v2_ff),
      .push_data (out_data),
      .pop       (pop),
      .pop_data  (rsp_data),
      .full      (out_full),
      .empty     (empty),
      .count     (out_count)
   );

   `AROC_ASSERT_IMPL(a_out_no_overflow, v2_ff, !out_full)

endmodule

[rtl/arc_route_orientation_concat.sv]
// Top level of the arc sequence orientation cost tracker.
// Usage: a service transaction is offered on req_data with push and taken at a rising
// edge where push is high and full is low. Each transaction yields exactly one result
// transaction on rsp_data, shown while empty is low and taken at an edge with pop high.
// Registers are written through csr_we, csr_index and csr_wdata; the user must write
// them only while idle, which the block itself does not enforce. A result passes from
// the middle queue through the scoring registers s1_ff and s2_ff into the result queue.
// Throughput: one transaction per cycle while full is low, set by the min-plus update
// of the four orientation costs, which is the loop carried from item to item.
// The front and back parts are joined by a queue of MID_DEPTH entries and results wait
// in a queue of OUT_DEPTH entries, so a stalled receiver first fills these; full rises
// only when the queue between the parts is full.
// Reset (synchronous, active high) sets all four costs to infinity, the load to zero,
// the registers to their defaults and empties both queues.
`include "arc_route_orientation_concat_assert.svh"

module arc_route_orientation_concat import aroc_pkg::*; #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   cfg_type                cfg_ff;
   logic                   accept;
   state_type              state_next;
   state_type              mid_data;
   logic                   mid_empty;
   logic                   mid_pop;
   logic [MID_CNT_W-1:0]   mid_count;

   assign accept = push && !full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vehicle_capacity <= CAPACITY_RESET;
         cfg_ff.time_limit       <= TIME_LIMIT_RESET;
         cfg_ff.capacity_penalty <= '0;
         cfg_ff.duration_penalty <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VEHICLE_CAPACITY: cfg_ff.vehicle_capacity <= csr_wdata[LOAD_W-1:0];
            CSR_TIME_LIMIT:       cfg_ff.time_limit       <= csr_wdata[COST_W-1:0];
            CSR_CAPACITY_PENALTY: cfg_ff.capacity_penalty <= csr_wdata[LOAD_W-1:0];
            CSR_DURATION_PENALTY: cfg_ff.duration_penalty <= csr_wdata[LOAD_W-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Front part: sequence state update.
   aroc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .state_next (state_next)
   );

   // Queue between the front and back parts.
   aroc_fifo #(
      .WIDTH ($bits(state_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (state_next),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .full      (full),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // Back part: scoring and result queue.
   aroc_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .src_empty (mid_empty),
      .src_data  (mid_data),
      .src_pop   (mid_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

   // An accepted transaction is waiting in the middle queue on the next cycle.
   `AROC_ASSERT_NEXT(a_mid_holds_item, accept, !mid_empty && (mid_count != '0))
   // An infinite from-from cost always gives the saturated score.
   `AROC_ASSERT_IMPL(a_inf_score, !empty && (rsp_data.best_from_from == COST_INF), rsp_data.penalized_cost == SCORE_MAX)
   // The minimum is no larger than any of the four costs.
   `AROC_ASSERT_IMPL(a_min_cost, !empty, (rsp_data.min_cost <= rsp_data.best_from_from) && (rsp_data.min_cost <= rsp_data.best_from_to) && (rsp_data.min_cost <= rsp_data.best_to_from) && (rsp_data.min_cost <= rsp_data.best_to_to))
   // A load within capacity carries no excess.
   `AROC_ASSERT_IMPL(a_no_excess, !empty && (rsp_data.total_load <= cfg_ff.vehicle_capacity), rsp_data.excess_load == '0)

endmodule

[tb/sv/orientation_cost_checker.sv]
// Checker that predicts and compares every result transaction of the orientation cost tracker.
`timescale 1ns / 1ps

module orientation_cost_checker import aroc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  req_type                req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     results_owed
);

   // Positions of the four orientation costs.
   localparam int ORI_FF = 0;
   localparam int ORI_FT = 1;
   localparam int ORI_TF = 2;
   localparam int ORI_TT = 3;

   logic [COST_W-1:0] seq_cost [4];
   logic [LOAD_W-1:0] seq_load;
   cfg_type           limits;
   rsp_type           owed_q [$];
   rsp_type           oldest;

   // Sum that sticks at the infinity code once it reaches it.
   function automatic logic [COST_W-1:0] cost_plus(input logic [COST_W-1:0] a,
                                                   input logic [COST_W-1:0] b);
      logic [COST_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return (total >= {1'b0, COST_INF}) ? COST_INF : total[COST_W-1:0];
   endfunction

   function automatic logic [COST_W-1:0] cost_lesser(input logic [COST_W-1:0] a,
                                                     input logic [COST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // Applies one service transaction to the sequence and returns the scored result.
   function automatic rsp_type advance_sequence(input req_type svc);
      logic [COST_W-1:0] nxt [4];
      logic [LOAD_W:0]   load_sum;
      logic [COST_W-1:0] ff;
      logic [63:0]       load_weight;
      logic [63:0]       time_weight;
      logic [63:0]       score;
      rsp_type           res;
      for (int i = 0; i < 4; i++) begin
         nxt[i] = seq_cost[i];
      end
      case (svc.opcode)
         OP_START: begin
            nxt[ORI_FF] = COST_INF;
            nxt[ORI_TT] = COST_INF;
            nxt[ORI_FT] = svc.cost_forward;
            nxt[ORI_TF] = svc.cost_reverse;
         end
         OP_APPEND: begin
            nxt[ORI_FT] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FF], svc.link_ff),
                                                cost_plus(seq_cost[ORI_FT], svc.link_tf)),
                                    svc.cost_forward);
            nxt[ORI_TT] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_TF], svc.link_ff),
                                                cost_plus(seq_cost[ORI_TT], svc.link_tf)),
                                    svc.cost_forward);
            nxt[ORI_FF] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FF], svc.link_ft),
                                                cost_plus(seq_cost[ORI_FT], svc.link_tt)),
                                    svc.cost_reverse);
            nxt[ORI_TF] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_TF], svc.link_ft),
                                                cost_plus(seq_cost[ORI_TT], svc.link_tt)),
                                    svc.cost_reverse);
         end
         OP_PREPEND: begin
            nxt[ORI_FF] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FF], svc.link_tf),
                                                cost_plus(seq_cost[ORI_TF], svc.link_tt)),
                                    svc.cost_forward);
            nxt[ORI_FT] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FT], svc.link_tf),
                                                cost_plus(seq_cost[ORI_TT], svc.link_tt)),
                                    svc.cost_forward);
            nxt[ORI_TF] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FF], svc.link_ff),
                                                cost_plus(seq_cost[ORI_TF], svc.link_ft)),
                                    svc.cost_reverse);
            nxt[ORI_TT] = cost_plus(cost_lesser(cost_plus(seq_cost[ORI_FT], svc.link_ff),
                                                cost_plus(seq_cost[ORI_TT], svc.link_ft)),
                                    svc.cost_reverse);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         seq_cost[i] = nxt[i];
      end

      // A start replaces the load; append and prepend add to it, stopping at the maximum.
      if (svc.opcode == OP_START) begin
         seq_load = {{(LOAD_W-DEM_W){1'b0}}, svc.demand};
      end else if (svc.opcode == OP_APPEND || svc.opcode == OP_PREPEND) begin
         load_sum = {1'b0, seq_load} + {{(LOAD_W-DEM_W+1){1'b0}}, svc.demand};
         seq_load = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
      end

      res.best_from_from = seq_cost[ORI_FF];
      res.best_from_to   = seq_cost[ORI_FT];
      res.best_to_from   = seq_cost[ORI_TF];
      res.best_to_to     = seq_cost[ORI_TT];
      res.min_cost       = cost_lesser(cost_lesser(seq_cost[ORI_FF], seq_cost[ORI_FT]),
                                       cost_lesser(seq_cost[ORI_TF], seq_cost[ORI_TT]));
      res.total_load     = seq_load;
      res.excess_load    = (seq_load > limits.vehicle_capacity) ?
                           seq_load - limits.vehicle_capacity : '0;

      // An infinite from-from cost forces both the time excess and the score to all ones.
      ff = seq_cost[ORI_FF];
      if (ff == COST_INF) begin
         res.excess_time    = COST_INF;
         res.penalized_cost = SCORE_MAX;
      end else begin
         res.excess_time = (ff > limits.time_limit) ? ff - limits.time_limit : '0;
         load_weight = {40'b0, res.excess_load};
         load_weight = load_weight * {40'b0, limits.capacity_penalty};
         time_weight = {32'b0, res.excess_time};
         time_weight = time_weight * {40'b0, limits.duration_penalty};
         score = {24'b0, ff, 8'b0} + load_weight + time_weight;
         res.penalized_cost = (score > {16'b0, SCORE_MAX}) ? SCORE_MAX : score[SCORE_W-1:0];
      end
      return res;
   endfunction

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Track register writes, predict on each accepted request and compare each result.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            seq_cost[i] = COST_INF;
         end
         seq_load                = '0;
         limits.vehicle_capacity = CAPACITY_RESET;
         limits.time_limit       = TIME_LIMIT_RESET;
         limits.capacity_penalty = '0;
         limits.duration_penalty = '0;
         owed_q.delete();
         results_owed <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VEHICLE_CAPACITY: limits.vehicle_capacity = csr_wdata[LOAD_W-1:0];
               CSR_TIME_LIMIT:       limits.time_limit       = csr_wdata[COST_W-1:0];
               CSR_CAPACITY_PENALTY: limits.capacity_penalty = csr_wdata[LOAD_W-1:0];
               CSR_DURATION_PENALTY: limits.duration_penalty = csr_wdata[LOAD_W-1:0];
               default: begin
               end
            endcase
         end
         if (push && !full) begin
            owed_q.insert(owed_q.size(), advance_sequence(req_data));
         end
         if (pop && !empty) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected result transaction: expected none, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest = owed_q.pop_front();
               check_field("best_from_from", oldest.best_from_from, rsp_data.best_from_from);
               check_field("best_from_to", oldest.best_from_to, rsp_data.best_from_to);
               check_field("best_to_from", oldest.best_to_from, rsp_data.best_to_from);
               check_field("best_to_to", oldest.best_to_to, rsp_data.best_to_to);
               check_field("min_cost", oldest.min_cost, rsp_data.min_cost);
               check_field("total_load", oldest.total_load, rsp_data.total_load);
               check_field("excess_load", oldest.excess_load, rsp_data.excess_load);
               check_field("excess_time", oldest.excess_time, rsp_data.excess_time);
               check_field("penalized_cost", oldest.penalized_cost, rsp_data.penalized_cost);
            end
         end
         results_owed <= owed_q.size();
      end
   end

endmodule

[tb/sv/arc_route_orientation_concat_test.sv]
// Top of the orientation cost tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module arc_route_orientation_concat_test;
   import aroc_pkg::*;

   // The one opcode the block leaves unused.
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int ITEMS_PER_PHASE = 240;
   localparam int PHASE_COUNT     = 8;
   localparam int HEAVY_PHASE     = 3;
   localparam int SETTLE_CYCLES   = 8;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_type                req_data  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_VEHICLE_CAPACITY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     mismatches;
   int                     results_owed;
   bit                     send_eager = 1'b0;
   bit                     take_eager = 1'b0;

   arc_route_orientation_concat u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   orientation_cost_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_type service(input logic [1:0] op, input logic [31:0] cf,
                                       input logic [31:0] cr, input logic [15:0] dem,
                                       input logic [31:0] lff, input logic [31:0] lft,
                                       input logic [31:0] ltf, input logic [31:0] ltt);
      req_type svc;
      svc.opcode       = op;
      svc.cost_forward = cf;
      svc.cost_reverse = cr;
      svc.demand       = dem;
      svc.link_ff      = lff;
      svc.link_ft      = lft;
      svc.link_tf      = ltf;
      svc.link_tt      = ltt;
      return svc;
   endfunction

   // Mostly small costs so sums stay finite, with some wide values and the boundary codes.
   function automatic logic [31:0] random_cost();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(0, 4095);
      end else if (pick < 85) begin
         return $urandom_range(0, 1 << 20);
      end else if (pick < 95) begin
         return $urandom;
      end else if (pick < 97) begin
         return '0;
      end else if (pick < 99) begin
         return 32'hFFFF_FFFE;
      end
      return COST_INF;
   endfunction

   function automatic req_type random_service(input logic [1:0] op, input bit heavy);
      logic [15:0] dem;
      if (heavy) begin
         dem = 16'($urandom_range(16'hF000, 16'hFFFF));
      end else if ($urandom_range(0, 99) < 85) begin
         dem = 16'($urandom_range(0, 255));
      end else begin
         dem = 16'($urandom_range(0, 16'hFFFF));
      end
      return service(op, random_cost(), random_cost(), dem, random_cost(), random_cost(),
                     random_cost(), random_cost());
   endfunction

   // Offers one request transaction after a random gap and waits until it is taken.
   task automatic send_item(input req_type svc);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= svc;
      do @(posedge clock); while (full);
   endtask

   // Stops offering and waits until every predicted result has been taken.
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [23:0] cap, input logic [31:0] tlim,
                               input logic [23:0] cpen, input logic [23:0] dpen);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_VEHICLE_CAPACITY;
      csr_wdata <= {8'b0, cap};
      @(posedge clock);
      csr_index <= CSR_TIME_LIMIT;
      csr_wdata <= tlim;
      @(posedge clock);
      csr_index <= CSR_CAPACITY_PENALTY;
      csr_wdata <= {8'b0, cpen};
      @(posedge clock);
      csr_index <= CSR_DURATION_PENALTY;
      csr_wdata <= {8'b0, dpen};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: a random stall before each result transaction is taken.
   initial begin : result_taker
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = take_eager ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   initial begin : stimulus
      int      issued;
      int      seq_len;
      bit      broken;
      bit      heavy;
      logic [1:0] op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: the all-infinity state after reset, the unused opcode, boundary values.
      send_item(service(OP_PREPEND, 5, 7, 100, 1, 2, 3, 4));
      send_item(service(OP_APPEND, 9, 8, 16'hFFFF, 0, 0, 0, 0));
      send_item(service(OP_RESERVED, COST_INF, COST_INF, 16'hFFFF, COST_INF, COST_INF,
                        COST_INF, COST_INF));
      send_item(service(OP_START, 0, 0, 0, 0, 0, 0, 0));
      send_item(service(OP_APPEND, 0, 0, 0, 0, 0, 0, 0));
      send_item(service(OP_START, 32'hFFFF_FFFE, 1, 16'hFFFF, 0, 0, 0, 0));
      send_item(service(OP_APPEND, 1, 1, 1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                        32'hFFFF_FFFE));
      send_item(service(OP_START, 10, 20, 5, 0, 0, 0, 0));
      send_item(service(OP_APPEND, 5, 6, 7, 1, 2, 3, 4));
      send_item(service(OP_PREPEND, 11, 12, 13, 7, 8, 9, 10));
      send_item(service(OP_APPEND, 3, 4, 2, COST_INF, 5, 6, 7));
      send_item(service(OP_PREPEND, COST_INF, 2, 1, 1, 1, 1, 1));
      send_item(service(OP_RESERVED, 0, 0, 0, 0, 0, 0, 0));
      send_item(service(OP_START, COST_INF, COST_INF, 16'h8000, 0, 0, 0, 0));
      send_item(service(OP_APPEND, 1, 2, 16'h7FFF, 3, 4, 5, 6));
      send_item(service(OP_START, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5555, 0, 0, 0, 0));
      send_item(service(OP_PREPEND, 32'h7FFF_FFFF, 32'h8000_0000, 16'hAAAA, 0, 0, 0, 0));

      // Random phases, each under its own register setting and idling pattern.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         heavy = (phase == HEAVY_PHASE);
         if (phase == 1) begin
            write_limits('0, '0, LOAD_MAX, LOAD_MAX);
         end else if (phase == 2) begin
            write_limits(CAPACITY_RESET, TIME_LIMIT_RESET, '0, '0);
         end else if (phase == HEAVY_PHASE) begin
            write_limits(24'($urandom_range(0, 24'hFF_FFFF)), $urandom_range(0, 32'hFFFF_FFFE),
                         24'($urandom_range(0, 24'hFF_FFFF)),
                         24'($urandom_range(0, 24'hFF_FFFF)));
         end else if (phase > 0) begin
            write_limits(24'($urandom_range(0, 3000)), $urandom_range(0, 40000),
                         24'($urandom_range(0, 24'hFF_FFFF)),
                         24'($urandom_range(0, 24'hFF_FFFF)));
         end
         send_eager = (phase % 3 == 1) || (phase == 6);
         take_eager = (phase % 3 == 2) || (phase == 6);
         issued = 0;
         while (issued < ITEMS_PER_PHASE) begin
            // A sequence opens with a start unless it is deliberately broken.
            seq_len = heavy ? 300 : $urandom_range(1, 12);
            broken  = ($urandom_range(0, 19) == 0);
            for (int k = 0; k < seq_len; k++) begin
               if (k == 0 && !broken) begin
                  op = OP_START;
               end else if ($urandom_range(0, 29) == 0) begin
                  op = OP_RESERVED;
               end else begin
                  op = $urandom_range(0, 1) ? OP_APPEND : OP_PREPEND;
               end
               send_item(random_service(op, heavy));
               issued++;
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/aroc_pkg.sv
rtl/aroc_fifo.sv
rtl/aroc_front.sv
rtl/aroc_back.sv
rtl/arc_route_orientation_concat.sv
tb/sv/orientation_cost_checker.sv
tb/sv/arc_route_orientation_concat_test.sv
